// ===== rtl/cbf_pkg.sv =====
// Shared types and constants of the cubic Bezier flattener.
`default_nettype none
package cbf_pkg;

	localparam int COORD_W = 24;
	localparam int T_W     = 16;
	localparam int IDX_W   = 6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [T_W-1:0]            tval_t;
	typedef logic [IDX_W-1:0]          idx_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
	} curve_t;

	typedef struct packed {
		coord_t pt_x;
		coord_t pt_y;
		idx_t   step_index;
		logic   last;
	} point_t;

	// What the sequencer hands to the interpolation pipeline each cycle.
	typedef struct packed {
		logic  valid;
		logic  last;
		idx_t  step_index;
		tval_t t;
	} issue_t;

	typedef struct packed {
		logic valid;
		logic last;
		idx_t step_index;
	} ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cbf_seq.sv =====
// Sequencer: holds the current curve and issues one parameter value t per cycle.
`default_nettype none
module cbf_seq #(
	parameter int STEPS = 20
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire cbf_pkg::curve_t curve,
	output logic                busy,
	output cbf_pkg::curve_t     pts,
	output cbf_pkg::issue_t     issue
);

	localparam int KW    = $clog2(STEPS);
	localparam int RW    = $clog2(2 * STEPS);
	localparam int Q_INC = 65536 / STEPS;
	localparam int R_INC = 65536 % STEPS;

	cbf_pkg::curve_t curve_q;
	logic [KW-1:0]   k_q;
	cbf_pkg::tval_t  q_q;
	logic [RW-1:0]   r_q;
	logic            active_q;

	logic            at_end;
	logic            accept;
	logic [RW-1:0]   r_sum;
	logic            carry;

	assign at_end = (k_q == KW'(STEPS - 1));
	assign busy   = active_q && !at_end;
	assign accept = start && !busy;

	// t_k = round(k*65536/STEPS) is kept as quotient and remainder and stepped by 65536/STEPS.
	assign r_sum = r_q + RW'(R_INC);
	assign carry = (r_sum >= RW'(STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
			q_q      <= '0;
			r_q      <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			k_q      <= '0;
			q_q      <= '0;
			r_q      <= RW'(STEPS / 2);
		end else if (active_q) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				k_q <= k_q + KW'(1);
				q_q <= q_q + cbf_pkg::T_W'(Q_INC) + cbf_pkg::T_W'(carry);
				r_q <= carry ? (r_sum - RW'(STEPS)) : r_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			curve_q <= curve;
		end
	end

	assign pts              = curve_q;
	assign issue.valid      = active_q;
	assign issue.last       = at_end;
	assign issue.step_index = cbf_pkg::IDX_W'(k_q);
	assign issue.t          = q_q;

endmodule
`default_nettype wire

// ===== rtl/cbf_lerp.sv =====
// Two-stage linear interpolator: multiply, then round, add and saturate.
`default_nettype none
module cbf_lerp (
	input  wire logic            clk,
	input  wire cbf_pkg::coord_t a,
	input  wire cbf_pkg::coord_t b,
	input  wire cbf_pkg::tval_t  t,
	output cbf_pkg::coord_t      r
);

	logic signed [24:0] diff;
	logic signed [41:0] prod;
	logic signed [41:0] prod_s1;
	cbf_pkg::coord_t    a_s1;
	logic signed [41:0] adj;
	logic signed [26:0] sum;
	cbf_pkg::coord_t    sat;
	cbf_pkg::coord_t    r_s2;

	// a*(1-t) + b*t is a + (b-a)*t/65536, so only the difference needs a multiplier.
	assign diff = $signed({b[23], b}) - $signed({a[23], a});
	assign prod = diff * $signed({1'b0, t});

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		a_s1    <= a;
	end

	assign adj = prod_s1 + 42'sd32768;
	assign sum = $signed({{3{a_s1[23]}}, a_s1}) + $signed({adj[41], adj[41:16]});

	always_comb begin
		if (sum[26:23] == 4'b0000 || sum[26:23] == 4'b1111) begin
			sat = sum[23:0];
		end else if (sum[26]) begin
			sat = {1'b1, 23'd0};
		end else begin
			sat = {1'b0, {23{1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= sat;
	end

	assign r = r_s2;

endmodule
`default_nettype wire

// ===== rtl/cbf_axis.sv =====
// De Casteljau evaluation of one coordinate: three interpolation levels, six stages.
`default_nettype none
module cbf_axis (
	input  wire logic            clk,
	input  wire cbf_pkg::coord_t c0,
	input  wire cbf_pkg::coord_t c1,
	input  wire cbf_pkg::coord_t c2,
	input  wire cbf_pkg::coord_t c3,
	input  wire cbf_pkg::tval_t  t,
	output cbf_pkg::coord_t      r
);

	cbf_pkg::coord_t l1_a, l1_b, l1_e;
	cbf_pkg::coord_t l2_d, l2_f;
	cbf_pkg::tval_t  t_s1, t_s2, t_s3, t_s4;

	// t follows the data so that each level sees the value its operands were made with.
	always_ff @(posedge clk) begin
		t_s1 <= t;
		t_s2 <= t_s1;
		t_s3 <= t_s2;
		t_s4 <= t_s3;
	end

	cbf_lerp u_l1a (.clk(clk), .a(c0), .b(c1), .t(t), .r(l1_a));
	cbf_lerp u_l1b (.clk(clk), .a(c1), .b(c2), .t(t), .r(l1_b));
	cbf_lerp u_l1e (.clk(clk), .a(c2), .b(c3), .t(t), .r(l1_e));

	cbf_lerp u_l2d (.clk(clk), .a(l1_a), .b(l1_b), .t(t_s2), .r(l2_d));
	cbf_lerp u_l2f (.clk(clk), .a(l1_b), .b(l1_e), .t(t_s2), .r(l2_f));

	cbf_lerp u_l3 (.clk(clk), .a(l2_d), .b(l2_f), .t(t_s4), .r(r));

endmodule
`default_nettype wire

// ===== rtl/cubic_bezier_flattener_top.sv =====
// Top level of the cubic Bezier flattener.
// A curve item is taken when start is high and busy is low; the block then puts out STEPS
// points, one per cycle, for k = 0 .. STEPS-1, each shown for one cycle with point_valid high.
// The first point comes out after the sequencer register and the interpolation pipeline
// (three levels, each a multiply stage and a rounding stage).
// busy drops in the cycle that issues the final point, so a new curve can follow at once;
// the sequencer issues one t per cycle while a curve is active.
// The receiver cannot stall the block: every point must be taken in the cycle it is shown.
`default_nettype none
module cubic_bezier_flattener_top #(
	parameter int STEPS = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire cbf_pkg::curve_t curve,
	output logic                 busy,
	output logic                 point_valid,
	output cbf_pkg::point_t      point
);

	cbf_pkg::curve_t pts;
	cbf_pkg::issue_t issue;
	cbf_pkg::ctl_t   ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	cbf_pkg::coord_t x_r, y_r;

	cbf_seq #(.STEPS(STEPS)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.curve  (curve),
		.busy   (busy),
		.pts    (pts),
		.issue  (issue)
	);

	cbf_axis u_axis_x (
		.clk (clk),
		.c0  (pts.p0_x),
		.c1  (pts.p1_x),
		.c2  (pts.p2_x),
		.c3  (pts.p3_x),
		.t   (issue.t),
		.r   (x_r)
	);

	cbf_axis u_axis_y (
		.clk (clk),
		.c0  (pts.p0_y),
		.c1  (pts.p1_y),
		.c2  (pts.p2_y),
		.c3  (pts.p3_y),
		.t   (issue.t),
		.r   (y_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s1 <= '{valid: issue.valid, last: issue.last, step_index: issue.step_index};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	assign point_valid      = ctl_s6.valid;
	assign point.pt_x       = x_r;
	assign point.pt_y       = y_r;
	assign point.step_index = ctl_s6.step_index;
	assign point.last       = ctl_s6.last;

endmodule
`default_nettype wire

// ===== rtl/cbf_checker.sv =====
// Port-level checks of the flattener and the bind that attaches them.
`default_nettype none
module cbf_checker #(
	parameter int STEPS = 20
) (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            point_valid,
	input wire cbf_pkg::point_t point
);

	// A taken curve produces its first point, with step index zero.
	a_first_point: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 (point_valid && point.step_index == '0))
		else $error("first point of a curve missing or misnumbered");

	// Points of one curve come in consecutive cycles with rising index.
	a_consecutive: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point.last |=>
			(point_valid && point.step_index == $past(point.step_index) + 6'd1))
		else $error("gap or wrong index inside a curve");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point.last |-> point.step_index == 6'(STEPS - 1))
		else $error("last flag on the wrong point");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a curve was taken");

endmodule

bind cubic_bezier_flattener_top cbf_checker #(.STEPS(STEPS)) u_cbf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.point_valid (point_valid),
	.point       (point)
);
`default_nettype wire
